### rtl/psd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and status codes for the percent segment decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       seg_last;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic [3:0] status;
  } out_t;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_EMPTY       = 4'd1;
  localparam logic [3:0] ST_BAD_ESCAPE  = 4'd2;
  localparam logic [3:0] ST_ESC_LITERAL = 4'd3;
  localparam logic [3:0] ST_BAD_LEAD    = 4'd4;
  localparam logic [3:0] ST_TRUNCATED   = 4'd5;
  localparam logic [3:0] ST_BAD_CONT    = 4'd6;
  localparam logic [3:0] ST_NONCANON    = 4'd7;
  localparam logic [3:0] ST_CONTROL     = 4'd8;
  localparam logic [3:0] ST_DOT         = 4'd9;

  // percent error codes
  localparam logic [1:0] PE_NONE    = 2'd0;
  localparam logic [1:0] PE_BAD_ESC = 2'd1;
  localparam logic [1:0] PE_ESC_LIT = 2'd2;

  // UTF-8 error codes (status minus three)
  localparam logic [2:0] UE_NONE     = 3'd0;
  localparam logic [2:0] UE_BAD_LEAD = 3'd1;
  localparam logic [2:0] UE_BAD_CONT = 3'd3;
  localparam logic [2:0] UE_NONCANON = 3'd4;
  localparam logic [2:0] UE_CONTROL  = 3'd5;

  // escape phases
  localparam logic [1:0] EP_IDLE = 2'd0;
  localparam logic [1:0] EP_HIGH = 2'd1;
  localparam logic [1:0] EP_LOW  = 2'd2;

endpackage
`default_nettype wire

### rtl/psd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_core
// Segment state and single-pass percent decode plus UTF-8 check per byte.
// ----------------------------------------------------------------------------
module psd_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire psd_pkg::in_t item,
  output psd_pkg::out_t     res
);
  import psd_pkg::*;

  logic [1:0]  escape_phase, escape_phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [1:0]  seq_remaining, seq_remaining_next;
  logic [2:0]  seq_length, seq_length_next;
  logic [20:0] code_accum, code_accum_next;
  logic        cont_bad, cont_bad_next;
  logic [1:0]  percent_err, percent_err_next;
  logic [2:0]  utf_err, utf_err_next;
  logic [1:0]  decoded_count, decoded_count_next;
  logic        all_dots, all_dots_next;

  logic        emit;
  logic [7:0]  ev;
  logic [7:0]  esc_val;
  logic [20:0] acc_shift;
  logic        cb_upd;
  logic [1:0]  pe_final;
  logic [3:0]  st;

  function automatic logic unreserved(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h5F ||
           b == 8'h7E || b == 8'h2D;
  endfunction

  function automatic logic up_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [7:0] d;
    d = (b <= 8'h39) ? b - 8'h30 : b - 8'h37;
    return d[3:0];
  endfunction

  // classify a completed sequence; UE_NONE when it is fine
  function automatic logic [2:0] finish_code(input logic [20:0] cp,
                                             input logic [2:0]  len,
                                             input logic        bad);
    logic [2:0] c;
    c = UE_NONE;
    if (bad) begin
      c = UE_BAD_CONT;
    end else if ((len == 3'd3 && cp < 21'h800) || (len == 3'd4 && cp < 21'h10000) ||
                 (cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF) begin
      c = UE_NONCANON;
    end else if (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)) begin
      c = UE_CONTROL;
    end
    return c;
  endfunction

  assign esc_val   = {high_nibble, hex_nib(item.in_byte)};
  assign acc_shift = {code_accum[14:0], ev[5:0]};
  assign cb_upd    = cont_bad | (ev[7:6] != 2'b10);

  always_comb begin
    escape_phase_next  = escape_phase;
    high_nibble_next   = high_nibble;
    seq_remaining_next = seq_remaining;
    seq_length_next    = seq_length;
    code_accum_next    = code_accum;
    cont_bad_next      = cont_bad;
    percent_err_next   = percent_err;
    utf_err_next       = utf_err;
    decoded_count_next = decoded_count;
    all_dots_next      = all_dots;
    emit               = 1'b0;
    ev                 = 8'h00;
    pe_final           = PE_NONE;
    st                 = ST_OK;

    if (item.byte_present && percent_err == PE_NONE) begin
      case (escape_phase)
        EP_IDLE: begin
          if (unreserved(item.in_byte)) begin
            emit = 1'b1;
            ev   = item.in_byte;
          end else if (item.in_byte == 8'h25) begin
            escape_phase_next = EP_HIGH;
          end else begin
            percent_err_next = PE_BAD_ESC;
          end
        end
        EP_HIGH: begin
          if (up_hex(item.in_byte)) begin
            high_nibble_next  = hex_nib(item.in_byte);
            escape_phase_next = EP_LOW;
          end else begin
            percent_err_next  = PE_BAD_ESC;
            escape_phase_next = EP_IDLE;
          end
        end
        default: begin
          escape_phase_next = EP_IDLE;
          if (!up_hex(item.in_byte)) begin
            percent_err_next = PE_BAD_ESC;
          end else if (unreserved(esc_val)) begin
            percent_err_next = PE_ESC_LIT;
          end else begin
            emit = 1'b1;
            ev   = esc_val;
          end
        end
      endcase
    end

    if (emit) begin
      if (decoded_count != 2'd3) decoded_count_next = decoded_count + 2'd1;
      if (ev != 8'h2E) all_dots_next = 1'b0;
      if (utf_err == UE_NONE) begin
        if (seq_remaining == 2'd0) begin
          if (ev <= 8'h7F) begin
            utf_err_next = finish_code({13'd0, ev}, 3'd1, 1'b0);
          end else if (ev >= 8'hC2 && ev <= 8'hDF) begin
            code_accum_next    = {16'd0, ev[4:0]};
            seq_length_next    = 3'd2;
            seq_remaining_next = 2'd1;
          end else if (ev >= 8'hE0 && ev <= 8'hEF) begin
            code_accum_next    = {17'd0, ev[3:0]};
            seq_length_next    = 3'd3;
            seq_remaining_next = 2'd2;
          end else if (ev >= 8'hF0 && ev <= 8'hF4) begin
            code_accum_next    = {18'd0, ev[2:0]};
            seq_length_next    = 3'd4;
            seq_remaining_next = 2'd3;
          end else begin
            utf_err_next = UE_BAD_LEAD;
          end
        end else if (seq_remaining == 2'd1) begin
          utf_err_next       = finish_code(acc_shift, seq_length, cb_upd);
          code_accum_next    = 21'd0;
          seq_length_next    = 3'd0;
          seq_remaining_next = 2'd0;
          cont_bad_next      = 1'b0;
        end else begin
          code_accum_next    = acc_shift;
          cont_bad_next      = cb_upd;
          seq_remaining_next = seq_remaining - 2'd1;
        end
      end
    end

    if (item.seg_last) begin
      pe_final = percent_err_next;
      if (percent_err_next == PE_NONE && escape_phase_next != EP_IDLE) pe_final = PE_BAD_ESC;
      if (pe_final != PE_NONE) begin
        st = {2'b00, pe_final} + 4'd1;
      end else if (decoded_count_next == 2'd0) begin
        st = ST_EMPTY;
      end else if (utf_err_next != UE_NONE) begin
        st = {1'b0, utf_err_next} + 4'd3;
      end else if (seq_remaining_next != 2'd0) begin
        st = ST_TRUNCATED;
      end else if (all_dots_next && decoded_count_next <= 2'd2) begin
        st = ST_DOT;
      end
      // segment closed: return to the reset state
      escape_phase_next  = EP_IDLE;
      high_nibble_next   = 4'd0;
      seq_remaining_next = 2'd0;
      seq_length_next    = 3'd0;
      code_accum_next    = 21'd0;
      cont_bad_next      = 1'b0;
      percent_err_next   = PE_NONE;
      utf_err_next       = UE_NONE;
      decoded_count_next = 2'd0;
      all_dots_next      = 1'b1;
    end

    res.out_valid = emit;
    res.out_byte  = ev;
    res.done_res  = item.seg_last;
    res.status    = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase  <= EP_IDLE;
      high_nibble   <= 4'd0;
      seq_remaining <= 2'd0;
      seq_length    <= 3'd0;
      code_accum    <= 21'd0;
      cont_bad      <= 1'b0;
      percent_err   <= PE_NONE;
      utf_err       <= UE_NONE;
      decoded_count <= 2'd0;
      all_dots      <= 1'b1;
    end else if (take) begin
      escape_phase  <= escape_phase_next;
      high_nibble   <= high_nibble_next;
      seq_remaining <= seq_remaining_next;
      seq_length    <= seq_length_next;
      code_accum    <= code_accum_next;
      cont_bad      <= cont_bad_next;
      percent_err   <= percent_err_next;
      utf_err       <= utf_err_next;
      decoded_count <= decoded_count_next;
      all_dots      <= all_dots_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.seg_last |=> escape_phase == EP_IDLE && decoded_count == 2'd0 && all_dots)
    else $error("segment state not cleared after last item");
  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    seq_remaining != 2'd0 |-> {1'b0, seq_remaining} + 3'd1 <= seq_length)
    else $error("sequence count exceeds sequence length");
  a_pe_code: assert property (@(posedge clk) disable iff (rst)
    percent_err != 2'd3 && escape_phase != 2'd3)
    else $error("illegal percent error or escape phase");
  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    take && res.out_valid && !item.seg_last |=> decoded_count != 2'd0)
    else $error("decoded byte not counted");
`endif

endmodule
`default_nettype wire

### rtl/psd_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psd_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module psd_skid (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire psd_pkg::out_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output psd_pkg::out_t      out_data
);
  import psd_pkg::*;

  out_t head, spare;
  logic head_full, spare_full;
  logic push, pop;

  assign in_ready  = !spare_full;
  assign out_valid = head_full;
  assign out_data  = head;
  assign push      = in_valid && in_ready;
  assign pop       = head_full && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full  <= 1'b0;
      spare_full <= 1'b0;
    end else if (spare_full) begin
      if (pop) begin
        head_full  <= 1'b1;
        spare_full <= 1'b0;
      end
    end else if (!head_full || pop) begin
      head_full <= push;
    end else if (push) begin
      spare_full <= 1'b1;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (spare_full) begin
      if (pop) head <= spare;
    end else if (!head_full || pop) begin
      if (push) head <= in_data;
    end else if (push) begin
      spare <= in_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_order: assert property (@(posedge clk) disable iff (rst)
    spare_full |-> head_full)
    else $error("skid entry held without output entry");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    head_full && !out_ready |=> head_full && $stable(head))
    else $error("stalled result changed");
  a_refill: assert property (@(posedge clk) disable iff (rst)
    spare_full && pop |=> head_full && !spare_full)
    else $error("skid entry lost on transfer");
`endif

endmodule
`default_nettype wire

### rtl/percent_segment_decoder_utf8_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// percent_segment_decoder_utf8_check
// Strict percent decoding of a path segment with UTF-8 validation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one raw byte per transfer,
// with byte_present and a seg_last flag. Every input transfer yields exactly
// one result transfer on out_valid/out_ready/out_data: out_data.out_valid
// marks a decoded byte, and on the segment's last item done_res is set with
// the final status.
// Each result is registered in the result buffer before it is presented.
// Throughput: one item per cycle while in_ready is high; the decode and UTF-8
// update for a byte is one combinational pass in front of the result buffer.
// A two-entry result buffer decouples the sides: input is taken while one
// result waits; in_ready drops only when both entries are full, i.e. after
// the receiver has stalled for two results.
// Reset (rst, synchronous) returns the segment state to its initial values
// and empties the result buffer. Segment state also clears after every
// last item, so segments follow each other back to back.
// ----------------------------------------------------------------------------
module percent_segment_decoder_utf8_check (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire psd_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output psd_pkg::out_t     out_data
);
  import psd_pkg::*;

  out_t res;
  logic take;

  assign take = in_valid && in_ready;

  psd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_data),
    .res  (res)
  );

  psd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
